// File: rtl/bmpdf_pkg.sv
// ----------------------------------------------------------------------------
// bmpdf_pkg
// Shared types and constants for the 24-bit BMP stream deframer.
// ----------------------------------------------------------------------------
package bmpdf_pkg;

    // Request codes on the input channel
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_SIG   = 3'd2,
        ST_BAD_BPP   = 3'd3,
        ST_BAD_OTHER = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_GAP    = 3'd1,
        PH_PIXEL  = 3'd2,
        PH_PAD    = 3'd3,
        PH_IDLE   = 3'd4
    } phase_t;

    localparam logic [5:0]  HEADER_LAST  = 6'd53;   // index of final header byte
    localparam logic [6:0]  HEADER_BYTES = 7'd54;
    localparam logic [15:0] SIG_BM       = 16'h4d42;
    localparam logic [15:0] SIG_CI       = 16'h4349;
    localparam logic [15:0] SIG_PT       = 16'h5450;
    localparam logic [15:0] BPP_24       = 16'd24;
    localparam logic [15:0] PLANES_ONE   = 16'd1;
    localparam logic [31:0] INFO_V3      = 32'd40;
    localparam logic [31:0] INFO_V4      = 32'd108;
    localparam logic [31:0] INFO_V5      = 32'd124;
    localparam logic [31:0] FILE_HDR_LEN = 32'd14;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } bmpdf_in_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        last_pixel;
    } bmpdf_out_t;

endpackage

// File: rtl/bmpdf_in_reg.sv
// ----------------------------------------------------------------------------
// bmpdf_in_reg
// Input register: holds one transfer until the core consumes it.
// ----------------------------------------------------------------------------
module bmpdf_in_reg
    import bmpdf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bmpdf_in_t s_data,
    input  logic      take,
    output logic      in_valid,
    output bmpdf_in_t in_data
);

    logic      valid_reg, valid_next;
    bmpdf_in_t data_reg, data_next;

    assign s_ready  = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_ready) begin
            valid_next = s_valid;
            data_next  = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

// File: rtl/bmpdf_core.sv
// ----------------------------------------------------------------------------
// bmpdf_core
// Parser state: header capture and check, gap skip, pixel assembly, padding.
// ----------------------------------------------------------------------------
module bmpdf_core
    import bmpdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  bmpdf_in_t  in_data,
    output logic       res_valid,
    output bmpdf_out_t res_data
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] sig_reg, sig_next;
    logic [31:0] rsv_reg, rsv_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] info_reg, info_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] planes_reg, planes_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] row_reg, row_next;
    logic [1:0]  bip_reg, bip_next;
    logic [15:0] hold_reg, hold_next;
    logic [1:0]  pad_reg, pad_next;
    logic [6:0]  gap_reg, gap_next;

    logic [31:0] col_inc, row_inc;
    logic        col_wrap, row_wrap;
    status_t     verdict;
    logic        is_end;
    logic [7:0]  b;
    logic [5:0]  off6, off10, off14, off18, off22;
    logic [6:0]  gap_start;

    function automatic logic [31:0] set_byte(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  val);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = val;
            2'd1:    w[15:8]  = val;
            2'd2:    w[23:16] = val;
            default: w[31:24] = val;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] set_half(input logic [15:0] word,
                                             input logic        lane,
                                             input logic [7:0]  val);
        logic [15:0] w;
        w = word;
        if (lane) begin
            w[15:8] = val;
        end else begin
            w[7:0] = val;
        end
        return w;
    endfunction

    assign is_end    = (in_data.req_type == REQ_END);
    assign b         = in_data.data_byte;
    assign col_inc   = col_reg + 32'd1;
    assign row_inc   = row_reg + 32'd1;
    assign col_wrap  = (col_inc == width_reg);
    assign row_wrap  = (row_inc == height_reg);
    assign off6      = pos_reg - 6'd6;
    assign off10     = pos_reg - 6'd10;
    assign off14     = pos_reg - 6'd14;
    assign off18     = pos_reg - 6'd18;
    assign off22     = pos_reg - 6'd22;
    assign gap_start = offset_reg[6:0] - HEADER_BYTES;

    // Header check, in priority order
    always_comb begin
        if (sig_reg != SIG_BM && sig_reg != SIG_CI && sig_reg != SIG_PT) begin
            verdict = ST_BAD_SIG;
        end else if (bpp_reg != BPP_24) begin
            verdict = ST_BAD_BPP;
        end else if (rsv_reg != 32'd0 || planes_reg != PLANES_ONE ||
                     (info_reg != INFO_V3 && info_reg != INFO_V4 &&
                      info_reg != INFO_V5) ||
                     offset_reg != info_reg + FILE_HDR_LEN) begin
            verdict = ST_BAD_OTHER;
        end else begin
            verdict = ST_OK;
        end
    end

    // Next state
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        rsv_next    = rsv_reg;
        offset_next = offset_reg;
        info_next   = info_reg;
        width_next  = width_reg;
        height_next = height_reg;
        planes_next = planes_reg;
        bpp_next    = bpp_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        hold_next   = hold_reg;
        pad_next    = pad_reg;
        gap_next    = gap_reg;
        if (advance) begin
            if (is_end) begin
                phase_next = PH_HEADER;
                pos_next   = 6'd0;
                col_next   = 32'd0;
                row_next   = 32'd0;
                bip_next   = 2'd0;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        // 16-bit fields start on even offsets, so bit 0 picks the lane
                        if (pos_reg < 6'd2) begin
                            sig_next = set_half(sig_reg, pos_reg[0], b);
                        end else if (pos_reg >= 6'd6 && pos_reg < 6'd10) begin
                            rsv_next = set_byte(rsv_reg, off6[1:0], b);
                        end else if (pos_reg >= 6'd10 && pos_reg < 6'd14) begin
                            offset_next = set_byte(offset_reg, off10[1:0], b);
                        end else if (pos_reg >= 6'd14 && pos_reg < 6'd18) begin
                            info_next = set_byte(info_reg, off14[1:0], b);
                        end else if (pos_reg >= 6'd18 && pos_reg < 6'd22) begin
                            width_next = set_byte(width_reg, off18[1:0], b);
                        end else if (pos_reg >= 6'd22 && pos_reg < 6'd26) begin
                            height_next = set_byte(height_reg, off22[1:0], b);
                        end else if (pos_reg >= 6'd26 && pos_reg < 6'd28) begin
                            planes_next = set_half(planes_reg, pos_reg[0], b);
                        end else if (pos_reg >= 6'd28 && pos_reg < 6'd30) begin
                            bpp_next = set_half(bpp_reg, pos_reg[0], b);
                        end
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == HEADER_LAST) begin
                            if (verdict != ST_OK || width_reg == 32'd0 ||
                                height_reg == 32'd0) begin
                                phase_next = PH_IDLE;
                            end else begin
                                gap_next   = gap_start;
                                phase_next = (gap_start != 7'd0) ? PH_GAP : PH_PIXEL;
                            end
                        end
                    end
                    PH_GAP: begin
                        gap_next = gap_reg - 7'd1;
                        if (gap_reg == 7'd1) begin
                            phase_next = PH_PIXEL;
                        end
                    end
                    PH_PIXEL: begin
                        case (bip_reg)
                            2'd0: begin
                                hold_next[7:0] = b;
                                bip_next       = 2'd1;
                            end
                            2'd1: begin
                                hold_next[15:8] = b;
                                bip_next        = 2'd2;
                            end
                            default: begin
                                bip_next = 2'd0;
                                if (col_wrap) begin
                                    col_next = 32'd0;
                                    row_next = row_inc;
                                    if (row_wrap) begin
                                        phase_next = PH_IDLE;
                                    end else begin
                                        pad_next = width_reg[1:0];
                                        if (width_reg[1:0] != 2'd0) begin
                                            phase_next = PH_PAD;
                                        end
                                    end
                                end else begin
                                    col_next = col_inc;
                                end
                            end
                        endcase
                    end
                    PH_PAD: begin
                        pad_next = pad_reg - 2'd1;
                        if (pad_reg == 2'd1) begin
                            phase_next = PH_PIXEL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        if (is_end) begin
            if (phase_reg == PH_HEADER) begin
                res_valid       = 1'b1;
                res_data.kind   = KIND_VERDICT;
                res_data.status = ST_SHORT;
            end
        end else if (phase_reg == PH_HEADER && pos_reg == HEADER_LAST) begin
            res_valid             = 1'b1;
            res_data.kind         = KIND_VERDICT;
            res_data.status       = verdict;
            res_data.image_width  = width_reg;
            res_data.image_height = height_reg;
        end else if (phase_reg == PH_PIXEL && bip_reg[1]) begin
            res_valid           = 1'b1;
            res_data.kind       = KIND_PIXEL;
            res_data.status     = ST_OK;
            res_data.blue       = hold_reg[7:0];
            res_data.green      = hold_reg[15:8];
            res_data.red        = b;
            res_data.last_pixel = col_wrap && row_wrap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 6'd0;
            col_reg   <= 32'd0;
            row_reg   <= 32'd0;
            bip_reg   <= 2'd0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            bip_reg   <= bip_next;
        end
        sig_reg    <= sig_next;
        rsv_reg    <= rsv_next;
        offset_reg <= offset_next;
        info_reg   <= info_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        planes_reg <= planes_next;
        bpp_reg    <= bpp_next;
        hold_reg   <= hold_next;
        pad_reg    <= pad_next;
        gap_reg    <= gap_next;
    end

endmodule

// File: rtl/bmpdf_out_reg.sv
// ----------------------------------------------------------------------------
// bmpdf_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module bmpdf_out_reg
    import bmpdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  bmpdf_out_t res_data,
    output logic       space,
    output logic       m_valid,
    input  logic       m_ready,
    output bmpdf_out_t m_data
);

    logic       valid_reg, valid_next;
    bmpdf_out_t data_reg, data_next;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            data_next  = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

// File: rtl/bmp24_stream_deframer.sv
// ----------------------------------------------------------------------------
// bmp24_stream_deframer
// Byte-stream parser for 24-bit BMP files: header verdict, then BGR pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer per file byte (req_type = data), or an end
//   marker (req_type = end) that closes the file and rearms the parser.
//   m_ channel: zero or one result per input transfer - a header verdict
//   after the 54th byte (or a short-header verdict on an early end marker),
//   and one pixel result per completed byte triple.
//   Path: a result reaches m_ once its byte has been accepted
//   (the byte sits in the input register, then the result register loads).
//   Throughput: one byte per cycle unless stalled; the core consumes the held
//   byte whenever the result register is empty or being drained.
//   Stall: when m_ready is low with a result pending, one more byte waits
//   in the input register, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous): both registers empty, parser back in
//   the header phase. Gap and row padding bytes are absorbed silently.
// ----------------------------------------------------------------------------
module bmp24_stream_deframer
    import bmpdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  bmpdf_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output bmpdf_out_t m_data
);

    logic       in_valid;
    bmpdf_in_t  in_data;
    logic       space;
    logic       advance;
    logic       res_valid;
    bmpdf_out_t res_data;

    // Core processes the held byte when the result register can take its output
    assign advance = in_valid && space;

    bmpdf_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .take     (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    bmpdf_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    bmpdf_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .res_data (res_data),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: tb/tb_bmp24_stream_deframer.sv
// ----------------------------------------------------------------------------
// tb_bmp24_stream_deframer
// Self-checking bench for the 24-bit BMP stream deframer. Whole files are
// streamed in byte by byte. They include good images with every signature,
// header size and row padding, corrupt headers, early end markers, empty
// and truncated images, and runs of random files. A parser model inside the
// bench tracks the header, gap, pixel and padding phases and queues the
// expected verdicts and pixels. Every result transfer is checked field by
// field against that queue.
// ----------------------------------------------------------------------------
module tb_bmp24_stream_deframer;
    import bmpdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Header fields that the bench controls; everything else is random filler
    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] rsv;
        logic [31:0] offs;
        logic [31:0] info;
        logic [31:0] wid;
        logic [31:0] hgt;
        logic [15:0] planes;
        logic [15:0] bpp;
    } bmp_hdr_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    bmpdf_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    bmpdf_out_t m_data;

    bit         idle_on = 1'b1;    // random gaps on both channels
    int         fail_count = 0;
    int         live_items = 0;    // accepted transfers, less data bytes that arrive in the idle phase

    bmpdf_out_t deframed_q[$];     // verdicts and pixels still to come out

    // Parser model state, at the block's widths but for pos_m, which is wider
    phase_t      ph_m;
    logic [7:0]  pos_m;
    logic [15:0] sig_m;
    logic [31:0] rsv_m;
    logic [31:0] offs_m;
    logic [31:0] info_m;
    logic [31:0] wid_m;
    logic [31:0] hgt_m;
    logic [15:0] planes_m;
    logic [15:0] bpp_m;
    logic [31:0] col_m;
    logic [31:0] row_m;
    logic [1:0]  lane_m;
    logic [15:0] hold_m;
    logic [1:0]  pad_m;
    logic [6:0]  gap_m;

    bmp24_stream_deframer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    task automatic parser_clear();
        ph_m     = PH_HEADER;
        pos_m    = '0;
        sig_m    = '0;
        rsv_m    = '0;
        offs_m   = '0;
        info_m   = '0;
        wid_m    = '0;
        hgt_m    = '0;
        planes_m = '0;
        bpp_m    = '0;
        col_m    = '0;
        row_m    = '0;
        lane_m   = '0;
        hold_m   = '0;
        pad_m    = '0;
        gap_m    = '0;
    endtask

    // Checks run in a fixed order: signature first, bit count next, the rest last
    function automatic status_t header_status();
        if (sig_m != SIG_BM && sig_m != SIG_CI && sig_m != SIG_PT) return ST_BAD_SIG;
        if (bpp_m != BPP_24) return ST_BAD_BPP;
        if (rsv_m != '0 || planes_m != PLANES_ONE ||
            (info_m != INFO_V3 && info_m != INFO_V4 && info_m != INFO_V5) ||
            offs_m != info_m + FILE_HDR_LEN) return ST_BAD_OTHER;
        return ST_OK;
    endfunction

    // Advance the model by one accepted transfer and queue what it yields
    task automatic deframe_step(input bmpdf_in_t item);
        bmpdf_out_t res;
        logic [7:0] b;
        b   = item.data_byte;
        res = '0;
        if (!(item.req_type == REQ_DATA && ph_m == PH_IDLE)) live_items++;

        if (item.req_type == REQ_END) begin
            // only an unfinished header is reported; any later end is silent
            if (ph_m == PH_HEADER) begin
                res.kind   = KIND_VERDICT;
                res.status = ST_SHORT;
                deframed_q.push_back(res);
            end
            parser_clear();
            return;
        end

        case (ph_m)
            PH_HEADER: begin
                // little-endian capture; file size and bytes after bpp are dropped
                if (pos_m < 2) sig_m[8*pos_m +: 8] = b;
                else if (pos_m >= 6 && pos_m < 10) rsv_m[8*(pos_m-6) +: 8] = b;
                else if (pos_m >= 10 && pos_m < 14) offs_m[8*(pos_m-10) +: 8] = b;
                else if (pos_m >= 14 && pos_m < 18) info_m[8*(pos_m-14) +: 8] = b;
                else if (pos_m >= 18 && pos_m < 22) wid_m[8*(pos_m-18) +: 8] = b;
                else if (pos_m >= 22 && pos_m < 26) hgt_m[8*(pos_m-22) +: 8] = b;
                else if (pos_m >= 26 && pos_m < 28) planes_m[8*(pos_m-26) +: 8] = b;
                else if (pos_m >= 28 && pos_m < 30) bpp_m[8*(pos_m-28) +: 8] = b;
                pos_m = pos_m + 8'd1;
                if (pos_m == 8'(HEADER_BYTES)) begin
                    res.kind         = KIND_VERDICT;
                    res.status       = header_status();
                    res.image_width  = wid_m;
                    res.image_height = hgt_m;
                    deframed_q.push_back(res);
                    if (res.status != ST_OK || wid_m == '0 || hgt_m == '0) begin
                        ph_m = PH_IDLE;
                    end else begin
                        gap_m = 7'(offs_m - 32'(HEADER_BYTES));
                        if (gap_m != '0) ph_m = PH_GAP;
                        else ph_m = PH_PIXEL;
                    end
                end
            end
            PH_GAP: begin
                gap_m = gap_m - 7'd1;
                if (gap_m == '0) ph_m = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (lane_m == 2'd0) begin
                    hold_m = {8'h00, b};
                    lane_m = 2'd1;
                end else if (lane_m == 2'd1) begin
                    hold_m[15:8] = b;
                    lane_m = 2'd2;
                end else begin
                    res.kind       = KIND_PIXEL;
                    res.status     = ST_OK;
                    res.blue       = hold_m[7:0];
                    res.green      = hold_m[15:8];
                    res.red        = b;
                    res.last_pixel = (col_m + 32'd1 == wid_m) && (row_m + 32'd1 == hgt_m);
                    deframed_q.push_back(res);
                    lane_m = 2'd0;
                    col_m  = col_m + 32'd1;
                    if (col_m == wid_m) begin
                        col_m = '0;
                        row_m = row_m + 32'd1;
                        if (row_m == hgt_m) begin
                            ph_m = PH_IDLE;
                        end else begin
                            // row padding is width mod 4 bytes
                            pad_m = wid_m[1:0];
                            if (pad_m != '0) ph_m = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD: begin
                pad_m = pad_m - 2'd1;
                if (pad_m == '0) ph_m = PH_PIXEL;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field check
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        bmpdf_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (deframed_q.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", m_data);
                fail_count++;
            end else begin
                want = deframed_q.pop_front();
                check_field("kind",         32'(want.kind),       32'(m_data.kind));
                check_field("status",       32'(want.status),     32'(m_data.status));
                check_field("image_width",  want.image_width,     m_data.image_width);
                check_field("image_height", want.image_height,    m_data.image_height);
                check_field("blue",         32'(want.blue),       32'(m_data.blue));
                check_field("green",        32'(want.green),      32'(m_data.green));
                check_field("red",          32'(want.red),        32'(m_data.red));
                check_field("last_pixel",   32'(want.last_pixel), 32'(m_data.last_pixel));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Called on a rising edge; returns on the edge at which the transfer happens
    task automatic send_transfer(input logic req, input logic [7:0] b);
        bmpdf_in_t item;
        item.req_type  = req;
        item.data_byte = b;
        if (idle_on) begin
            while ($urandom_range(0, 99) < 25) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        deframe_step(item);
    endtask

    // Hold off the sender until every queued result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        // two-stage pipe: give any unexpected stragglers room to show up
        repeat (6) @(posedge aclk);
    endtask

    function automatic bmp_hdr_t good_header(input logic [15:0] sig, input logic [31:0] info,
                                             input logic [31:0] wid, input logic [31:0] hgt);
        bmp_hdr_t h;
        h.sig    = sig;
        h.rsv    = '0;
        h.info   = info;
        h.offs   = info + FILE_HDR_LEN;
        h.wid    = wid;
        h.hgt    = hgt;
        h.planes = PLANES_ONE;
        h.bpp    = BPP_24;
        return h;
    endfunction

    // Gap plus every row with its padding; only for small images
    function automatic int full_body(input bmp_hdr_t h);
        return int'(h.offs) - int'(HEADER_BYTES) +
               int'(h.hgt) * (3 * int'(h.wid) + int'(h.wid[1:0]));
    endfunction

    function automatic logic [7:0] header_byte(input bmp_hdr_t h, input int p);
        logic [7:0] b;
        b = 8'($urandom);
        if (p < 2) b = h.sig[8*p +: 8];
        else if (p >= 6 && p < 10) b = h.rsv[8*(p-6) +: 8];
        else if (p >= 10 && p < 14) b = h.offs[8*(p-10) +: 8];
        else if (p >= 14 && p < 18) b = h.info[8*(p-14) +: 8];
        else if (p >= 18 && p < 22) b = h.wid[8*(p-18) +: 8];
        else if (p >= 22 && p < 26) b = h.hgt[8*(p-22) +: 8];
        else if (p >= 26 && p < 28) b = h.planes[8*(p-26) +: 8];
        else if (p >= 28 && p < 30) b = h.bpp[8*(p-28) +: 8];
        return b;
    endfunction

    task automatic send_header(input bmp_hdr_t h, input int n_bytes);
        for (int p = 0; p < n_bytes; p++) send_transfer(REQ_DATA, header_byte(h, p));
    endtask

    task automatic send_end();
        send_transfer(REQ_END, 8'($urandom));
    endtask

    // Full header, then body_bytes of random payload, then the end marker
    task automatic send_file(input bmp_hdr_t h, input int body_bytes);
        send_header(h, int'(HEADER_BYTES));
        repeat (body_bytes) send_transfer(REQ_DATA, 8'($urandom));
        send_end();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_short_header();
        bmp_hdr_t h;
        h = good_header(SIG_BM, INFO_V3, 32'd2, 32'd2);
        send_end();                             // nothing at all
        send_end();                             // back-to-back markers
        send_header(h, 30);
        send_end();
        send_header(h, int'(HEADER_LAST));      // one byte short
        send_end();
        wait_drained();
    endtask

    // All signatures and header sizes; widths 1..4 cover every padding length.
    // Trailing bytes after the last pixel must be dropped.
    task automatic test_good_images();
        bmp_hdr_t h;
        h = good_header(SIG_BM, INFO_V3, 32'd1, 32'd2);
        send_file(h, full_body(h) + 5);
        h = good_header(SIG_CI, INFO_V4, 32'd2, 32'd2);
        send_file(h, full_body(h) + 5);
        h = good_header(SIG_PT, INFO_V5, 32'd3, 32'd2);
        send_file(h, full_body(h) + 5);
        h = good_header(SIG_BM, INFO_V3, 32'd4, 32'd2);
        send_file(h, full_body(h));
        wait_drained();
    endtask

    task automatic test_header_errors();
        bmp_hdr_t h;
        h = good_header(16'hFFFF, INFO_V3, 32'd1, 32'd1);
        h.bpp = 16'h0000;                       // signature outranks bit count
        send_file(h, 6);
        h = good_header(16'h0000, INFO_V3, 32'd1, 32'd1);
        send_file(h, 6);
        h = good_header(SIG_CI, INFO_V3, 32'd1, 32'd1);
        h.bpp = 16'd32;
        send_file(h, 6);
        h = good_header(SIG_BM, INFO_V3, 32'd1, 32'd1);
        h.bpp = 16'h0118;                       // low byte right, high byte not
        send_file(h, 6);
        h = good_header(SIG_BM, INFO_V3, 32'd1, 32'd1);
        h.rsv = 32'h8000_0000;
        send_file(h, 6);
        h = good_header(SIG_BM, INFO_V3, 32'd1, 32'd1);
        h.planes = 16'h0000;
        send_file(h, 6);
        h = good_header(SIG_PT, INFO_V3, 32'd1, 32'd1);
        h.planes = 16'hFFFF;
        send_file(h, 6);
        h = good_header(SIG_BM, 32'd41, 32'd1, 32'd1);
        send_file(h, 6);
        h = good_header(SIG_BM, INFO_V3, 32'd1, 32'd1);
        h.offs = 32'd122;                       // offset of a different header size
        send_file(h, 6);
        wait_drained();
    endtask

    task automatic test_empty_image();
        bmp_hdr_t h;
        h = good_header(SIG_BM, INFO_V3, 32'd0, 32'd3);
        send_file(h, 10);
        h = good_header(SIG_CI, INFO_V4, 32'd5, 32'd0);
        send_file(h, 10);
        wait_drained();
    endtask

    // End markers in the gap, in mid-pixel and in row padding: no result
    task automatic test_truncated_image();
        bmp_hdr_t h;
        h = good_header(SIG_CI, INFO_V4, 32'd2, 32'd2);
        send_file(h, 10);
        h = good_header(SIG_BM, INFO_V3, 32'd4, 32'd3);
        send_file(h, 20);
        h = good_header(SIG_PT, INFO_V5, 32'd3, 32'd3);
        send_file(h, 84 + 10);
        h = good_header(SIG_BM, INFO_V3, 32'd2, 32'd1);
        send_file(h, full_body(h));
        wait_drained();
    endtask

    task automatic test_extreme_dimensions();
        bmp_hdr_t h;
        h = good_header(SIG_BM, INFO_V3, 32'hFFFF_FFFF, 32'd1);
        send_file(h, 14);
        h = good_header(SIG_PT, INFO_V3, 32'd1, 32'hFFFF_FFFF);
        send_file(h, 20);
        h = good_header(SIG_CI, INFO_V5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        h.bpp = 16'hFFFF;
        h.rsv = 32'hFFFF_FFFF;
        send_file(h, 4);
        wait_drained();
    endtask

    // Mostly well-formed files with random content; the rest corrupt
    // headers, early ends and raw noise
    task automatic test_random_files(input int n_live, input bit with_idle);
        bmp_hdr_t    h;
        int          goal;
        int          pick;
        logic [15:0] sig;
        logic [31:0] info;
        logic [31:0] wid;
        goal    = live_items + n_live;
        idle_on = with_idle;
        while (live_items < goal) begin
            case ($urandom_range(0, 2))
                0: sig = SIG_BM;
                1: sig = SIG_CI;
                default: sig = SIG_PT;
            endcase
            case ($urandom_range(0, 2))
                0: info = INFO_V3;
                1: info = INFO_V4;
                default: info = INFO_V5;
            endcase
            wid  = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            h    = good_header(sig, info, wid, $urandom_range(1, 4));
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_file(h, full_body(h) +
                          (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0));
            end else if (pick < 75) begin
                send_file(h, $urandom_range(0, full_body(h) - 1));
            end else if (pick < 88) begin
                case ($urandom_range(0, 5))
                    0: h.sig    = 16'($urandom);
                    1: h.bpp    = 16'($urandom);
                    2: h.rsv    = $urandom | 32'd1;
                    3: h.planes = 16'($urandom);
                    4: h.info   = $urandom;
                    default: h.offs = $urandom;
                endcase
                h.wid = $urandom;
                h.hgt = $urandom;
                send_file(h, $urandom_range(0, 8));
            end else if (pick < 96) begin
                send_header(h, $urandom_range(0, int'(HEADER_LAST)));
                send_end();
            end else begin
                repeat ($urandom_range(1, 10)) begin
                    send_transfer(1'($urandom_range(0, 1)), 8'($urandom));
                end
                send_end();
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        parser_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_short_header();
        test_good_images();
        test_header_errors();
        test_empty_image();
        test_truncated_image();
        test_extreme_dimensions();
        test_random_files(120, 1'b0);   // full rate, no gaps on either side
        test_random_files(330, 1'b1);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
